/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file codel_checker. Each macro clocks on clk and
// is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/codel_pkg.sv */
// ----------------------------------------------------------------------------
// codel_pkg
// Shared widths, codes and inter-module structs of the CoDel drop decision.
// ----------------------------------------------------------------------------
package codel_pkg;

  localparam int TIME_BITS    = 48;
  localparam int CNT_W        = 32;
  localparam int INV_W        = 16;
  localparam int BACKLOG_W    = 32;
  localparam int MINB_W       = 16;
  localparam int APB_DW       = 64;
  localparam int PADDR_W      = 5;
  localparam int RECENT_SHIFT = 4;   // 16-interval window
  localparam int NEWTON_KEEP  = 47;  // low bits of v that reach the result
  localparam int NEWTON_LSB   = 31;

  localparam logic [63:0]          THREE_Q32 = 64'h3 << 32;
  localparam logic [INV_W-1:0]     INV_ONE   = {INV_W{1'b1}};

  localparam logic [TIME_BITS-1:0] TARGET_RST   = TIME_BITS'(5000);
  localparam logic [TIME_BITS-1:0] INTERVAL_RST = TIME_BITS'(100000);
  localparam logic [MINB_W-1:0]    MINB_RST     = MINB_W'(512);

  localparam logic [1:0] REG_TARGET   = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_MINB     = 2'd2;

  localparam logic [1:0] VERDICT_FORWARD = 2'd0;
  localparam logic [1:0] VERDICT_DROP    = 2'd1;
  localparam logic [1:0] VERDICT_EMPTY   = 2'd2;

  typedef struct packed {
    logic [TIME_BITS-1:0] target;
    logic [TIME_BITS-1:0] interval;
    logic [MINB_W-1:0]    min_backlog;
  } cfg_t;

  typedef struct packed {
    logic       in_load;
    logic       fad_step;
    logic       fad_clr;
    logic       drop_clr;
    logic       drop_set;
    logic       cnt_inc;
    logic       cnt_reentry;
    logic       cnt_one;
    logic       newt_sq;
    logic       newt_mul;
    logic       newt_upd;
    logic       sched_mul;
    logic       sched_add;
    logic       sched_from_now;
    logic       cae_load;
    logic       out_load;
    logic [1:0] verdict;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic ok;
    logic dropping;
    logic due;
    logic recent;
  } status_t;

endpackage

/* hw/rtl/codel_cfg.sv */
// ----------------------------------------------------------------------------
// codel_cfg
// APB register file: target, interval and minimum backlog.
// ----------------------------------------------------------------------------
module codel_cfg import codel_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [TIME_BITS-1:0] target_r;
  logic [TIME_BITS-1:0] interval_r;
  logic [MINB_W-1:0]    minb_r;
  logic [1:0]           idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:3];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= TARGET_RST;
      interval_r <= INTERVAL_RST;
      minb_r     <= MINB_RST;
    end else if (wr) begin
      case (idx)
        REG_TARGET:   target_r   <= pwdata[TIME_BITS-1:0];
        REG_INTERVAL: interval_r <= pwdata[TIME_BITS-1:0];
        REG_MINB:     minb_r     <= pwdata[MINB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET:   prdata = APB_DW'(target_r);
      REG_INTERVAL: prdata = APB_DW'(interval_r);
      REG_MINB:     prdata = APB_DW'(minb_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.target      = target_r;
  assign cfg.interval    = interval_r;
  assign cfg.min_backlog = minb_r;

endmodule

/* hw/rtl/codel_dp.sv */
// ----------------------------------------------------------------------------
// codel_dp
// Datapath: input word latch, CoDel state, Newton step, control law, output.
// ----------------------------------------------------------------------------
module codel_dp import codel_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  cmd_t                 cmd,
  output status_t              sts,
  input  logic                 in_queue_empty,
  input  logic [TIME_BITS-1:0] in_sojourn_time,
  input  logic [BACKLOG_W-1:0] in_backlog_bytes,
  input  logic [TIME_BITS-1:0] in_now,
  output logic [1:0]           out_verdict,
  output logic                 out_in_drop_state,
  output logic [CNT_W-1:0]     out_drop_count
);

  logic                       empty_r;
  logic [TIME_BITS-1:0]       soj_r;
  logic [BACKLOG_W-1:0]       backlog_r;
  logic [TIME_BITS-1:0]       now_r;
  logic                       dropping_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cae_r;
  logic [INV_W-1:0]           inv_r;
  logic [TIME_BITS-1:0]       fad_r;
  logic [TIME_BITS-1:0]       next_r;
  logic [2*INV_W-1:0]         x2_r;
  logic [63:0]                p2_r;
  logic [TIME_BITS+INV_W-1:0] prod_r;
  logic [1:0]                 verdict_r;
  logic                       drop_out_r;
  logic [CNT_W-1:0]           cnt_out_r;

  logic                       below;
  logic [TIME_BITS-1:0]       d_fad;
  logic [TIME_BITS-1:0]       d_next;
  logic [63:0]                v;
  logic [NEWTON_KEEP+INV_W-1:0] vmul;
  logic [TIME_BITS-1:0]       base;

  assign below  = (soj_r < cfg.target) ||
                  (backlog_r <= BACKLOG_W'(cfg.min_backlog));
  assign d_fad  = now_r - fad_r;
  assign d_next = now_r - next_r;

  assign sts.empty    = empty_r;
  assign sts.dropping = dropping_r;
  assign sts.ok       = !below && (fad_r != '0) && (d_fad != '0) && !d_fad[TIME_BITS-1];
  assign sts.due      = !d_next[TIME_BITS-1];
  assign sts.recent   = ({{RECENT_SHIFT{1'b0}}, d_next} <
                         {cfg.interval, {RECENT_SHIFT{1'b0}}});

  assign v    = (THREE_Q32 - p2_r) >> 2;
  assign vmul = (NEWTON_KEEP+INV_W)'(v[NEWTON_KEEP-1:0]) * (NEWTON_KEEP+INV_W)'(inv_r);
  assign base = cmd.sched_from_now ? now_r : next_r;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      empty_r   <= in_queue_empty;
      soj_r     <= in_sojourn_time;
      backlog_r <= in_backlog_bytes;
      now_r     <= in_now;
    end
    if (cmd.newt_sq)   x2_r   <= (2*INV_W)'(inv_r) * (2*INV_W)'(inv_r);
    if (cmd.newt_mul)  p2_r   <= 64'(cnt_r) * 64'(x2_r);
    if (cmd.sched_mul) prod_r <= (TIME_BITS+INV_W)'(cfg.interval) * (TIME_BITS+INV_W)'(inv_r);
    if (cmd.out_load) begin
      verdict_r  <= cmd.verdict;
      drop_out_r <= dropping_r;
      cnt_out_r  <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dropping_r <= 1'b0;
      cnt_r      <= '0;
      cae_r      <= '0;
      inv_r      <= '0;
      fad_r      <= '0;
      next_r     <= '0;
    end else begin
      if (cmd.drop_clr) dropping_r <= 1'b0;
      if (cmd.drop_set) dropping_r <= 1'b1;
      if (cmd.fad_clr) begin
        fad_r <= '0;
      end else if (cmd.fad_step) begin
        if (below) begin
          fad_r <= '0;
        end else if (fad_r == '0) begin
          fad_r <= now_r + cfg.interval;
        end
      end
      if (cmd.cnt_inc)     cnt_r <= cnt_r + CNT_W'(1);
      if (cmd.cnt_reentry) cnt_r <= (cnt_r - cae_r) | CNT_W'(1);
      if (cmd.cnt_one) begin
        cnt_r <= CNT_W'(1);
        inv_r <= INV_ONE;
      end
      if (cmd.newt_upd)  inv_r  <= vmul[NEWTON_LSB+INV_W-1:NEWTON_LSB];
      if (cmd.sched_add) next_r <= base + prod_r[TIME_BITS+INV_W-1:INV_W];
      if (cmd.cae_load)  cae_r  <= cnt_r;
    end
  end

  assign out_verdict       = verdict_r;
  assign out_in_drop_state = drop_out_r;
  assign out_drop_count    = cnt_out_r;

endmodule

/* hw/rtl/codel_ctrl.sv */
// ----------------------------------------------------------------------------
// codel_ctrl
// Sequencer: accepts a word, picks the CoDel branch, steps the Newton update
// and control law, and hands the result to the output register.
// ----------------------------------------------------------------------------
module codel_ctrl import codel_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_N1, S_N2, S_N3, S_S1, S_S2, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] verdict_r, verdict_nxt;
  logic       entry_r, entry_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    verdict_nxt   = verdict_r;
    entry_nxt     = entry_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    cmd           = '0;
    cmd.verdict   = verdict_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_load = in_valid;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        verdict_nxt = VERDICT_FORWARD;
        state_nxt   = S_DONE;
        if (sts.empty) begin
          cmd.drop_clr = 1'b1;
          cmd.fad_clr  = 1'b1;
          verdict_nxt  = VERDICT_EMPTY;
        end else begin
          cmd.fad_step = 1'b1;
          if (sts.dropping) begin
            if (!sts.ok) begin
              cmd.drop_clr = 1'b1;
            end else if (sts.due) begin
              cmd.cnt_inc = 1'b1;
              verdict_nxt = VERDICT_DROP;
              entry_nxt   = 1'b0;
              state_nxt   = S_N1;
            end
          end else if (sts.ok) begin
            cmd.drop_set = 1'b1;
            verdict_nxt  = VERDICT_DROP;
            entry_nxt    = 1'b1;
            if (sts.recent) begin
              cmd.cnt_reentry = 1'b1;
              state_nxt       = S_N1;
            end else begin
              cmd.cnt_one = 1'b1;
              state_nxt   = S_S1;
            end
          end
        end
      end
      S_N1: begin
        cmd.newt_sq = 1'b1;
        state_nxt   = S_N2;
      end
      S_N2: begin
        cmd.newt_mul = 1'b1;
        state_nxt    = S_N3;
      end
      S_N3: begin
        cmd.newt_upd = 1'b1;
        state_nxt    = S_S1;
      end
      S_S1: begin
        cmd.sched_mul = 1'b1;
        state_nxt     = S_S2;
      end
      S_S2: begin
        cmd.sched_add      = 1'b1;
        cmd.sched_from_now = entry_r;
        cmd.cae_load       = entry_r;
        state_nxt          = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      verdict_r   <= VERDICT_FORWARD;
      entry_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      verdict_r   <= verdict_nxt;
      entry_r     <= entry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/codel_drop_decision.sv */
// ----------------------------------------------------------------------------
// codel_drop_decision
// CoDel forward/drop decision, one result word per input word.
// ----------------------------------------------------------------------------
// One input word at a time: a word that forwards, reports an empty queue or
// needs no drop goes from acceptance through the evaluate and done states to
// the output register; a first drop on entering dropping state without recent
// history adds the control-law multiply and add steps between them; any drop
// that runs the Newton inverse-square-root step adds its square, multiply and
// update steps before those. A result still waiting to be taken holds the last
// step until it goes. The length of the sequence is set by the chain of
// dependent multiplies in the datapath (square, count product, Newton product,
// control-law product) each followed by a register. The next word is accepted
// once the current one is in the output register, even while that result still waits to be taken.
// Configuration is on an APB port with 64-bit data: target at 0x00, interval
// at 0x08, minimum backlog at 0x10; write it only while the block is idle.
module codel_drop_decision import codel_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_queue_empty,
  input  logic [TIME_BITS-1:0] in_sojourn_time,
  input  logic [BACKLOG_W-1:0] in_backlog_bytes,
  input  logic [TIME_BITS-1:0] in_now,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_verdict,
  output logic                 out_in_drop_state,
  output logic [CNT_W-1:0]     out_drop_count
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t sts;

  codel_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  codel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  codel_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .sts               (sts),
    .in_queue_empty    (in_queue_empty),
    .in_sojourn_time   (in_sojourn_time),
    .in_backlog_bytes  (in_backlog_bytes),
    .in_now            (in_now),
    .out_verdict       (out_verdict),
    .out_in_drop_state (out_in_drop_state),
    .out_drop_count    (out_drop_count)
  );

endmodule

/* hw/rtl/codel_checker.sv */
// ----------------------------------------------------------------------------
// codel_checker
// Port-level checks on the result channel of the drop decision block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module codel_checker import codel_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_verdict,
  input logic             out_in_drop_state,
  input logic [CNT_W-1:0] out_drop_count
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_verdict) && $stable(out_in_drop_state) && $stable(out_drop_count))
  `ASSERT_IMPLY(a_verdict_code, out_valid, out_verdict == VERDICT_FORWARD || out_verdict == VERDICT_DROP || out_verdict == VERDICT_EMPTY)
  `ASSERT_IMPLY(a_empty_leaves, out_valid && out_verdict == VERDICT_EMPTY, !out_in_drop_state)
  `ASSERT_IMPLY(a_drop_in_state, out_valid && out_verdict == VERDICT_DROP, out_in_drop_state)

endmodule

bind codel_drop_decision codel_checker u_chk (.*);
